// ----- hw/rtl/clam_pkg.sv -----
// Shared types, constants and fixed-point helpers for the look-at matrix core.
// No dependencies; compiled first.
package clam_pkg;

   // Vector widths entering the two normalizers.
   localparam int D_W     = 33;   // center - eye, 33-bit signed
   localparam int SR_W    = 64;   // forward x up, exact

   localparam int SQRT_STEPS = 32;   // one result bit (two radicand bits) per stage
   localparam int DIV_STEPS  = 31;   // one quotient bit per stage

   localparam logic signed [63:0] ONE30     = 64'sd1073741824;
   localparam logic signed [63:0] NEG_ONE30 = -64'sd1073741824;
   localparam logic [63:0]        HALF30    = 64'd536870912;

   typedef enum logic [1:0] {
      CSR_UP_X = 2'd0,
      CSR_UP_Y = 2'd1,
      CSR_UP_Z = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
   } in_type;

   typedef struct packed {
      logic signed [31:0] side_x;
      logic signed [31:0] side_y;
      logic signed [31:0] side_z;
      logic signed [31:0] cam_up_x;
      logic signed [31:0] cam_up_y;
      logic signed [31:0] cam_up_z;
      logic signed [31:0] back_x;
      logic signed [31:0] back_y;
      logic signed [31:0] back_z;
      logic signed [39:0] trans_side;
      logic signed [39:0] trans_up;
      logic signed [39:0] trans_fwd;
   } out_type;

   // Sideband carried through the second normalizer.
   typedef struct packed {
      logic              nz;
      logic [2:0][31:0]  fwd;
      logic [2:0][31:0]  eye;
   } side2_type;

   localparam int SIDE1_W = 96;
   localparam int SIDE2_W = $bits(side2_type);

   function automatic logic signed [63:0] mul32s(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p;
   endfunction

   // Shift right by 30, round half away from zero.
   function automatic logic signed [63:0] round30(input logic signed [63:0] v);
      logic [63:0] m;
      logic [63:0] r;
      m = v[63] ? (~v + 64'd1) : v;
      r = (m + HALF30) >> 30;
      return v[63] ? $signed(~r + 64'd1) : $signed(r);
   endfunction

   function automatic logic signed [31:0] sat30(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > ONE30) begin
         r = 32'sh4000_0000;
      end else if (v < NEG_ONE30) begin
         r = -32'sh4000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/clam_norm.sv -----
// Pipelined 3-vector normalizer to Q2.30: block scaling, squares, bit-per-stage
// square root and three lanes of bit-per-stage division. Uses clam_pkg.
module clam_norm #(
   parameter int W      = clam_pkg::D_W,
   parameter int SIDE_W = clam_pkg::SIDE1_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  logic [2:0][W-1:0]    in_vec,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_vld,
   output logic [2:0][31:0]     out_vec,
   output logic                 out_nz,
   output logic [SIDE_W-1:0]    out_side
);
   import clam_pkg::*;

   localparam int PW = $clog2(W + 1);

   typedef struct packed {
      logic [SIDE_W-1:0] side;
      logic              nz;
      logic [2:0]        neg;
      logic [2:0][29:0]  n;
   } carry_type;

   // stage A: magnitudes
   logic                a_vld_ff;
   logic [2:0][W-1:0]   a_mag_ff, a_mag_in;
   logic [2:0]          a_neg_ff;
   logic [SIDE_W-1:0]   a_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_mag_in[i] = in_vec[i][W-1] ? (~in_vec[i] + W'(1)) : in_vec[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= in_vld;
   end

   always_ff @(posedge clock) begin
      a_mag_ff  <= a_mag_in;
      a_side_ff <= in_side;
      for (int i = 0; i < 3; i++) a_neg_ff[i] <= in_vec[i][W-1];
   end

   // stage B: leading one of the largest magnitude (= of the OR)
   logic                b_vld_ff;
   logic [PW-1:0]       b_pos_ff, b_pos_in;
   logic [2:0][W-1:0]   b_mag_ff;
   logic [2:0]          b_neg_ff;
   logic [SIDE_W-1:0]   b_side_ff;
   logic [W-1:0]        or_all;

   always_comb begin
      or_all   = a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2];
      b_pos_in = '0;
      for (int i = 0; i < W; i++) begin
         if (or_all[i]) b_pos_in = PW'(i + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else       b_vld_ff <= a_vld_ff;
   end

   always_ff @(posedge clock) begin
      b_pos_ff  <= b_pos_in;
      b_mag_ff  <= a_mag_ff;
      b_neg_ff  <= a_neg_ff;
      b_side_ff <= a_side_ff;
   end

   // stage C: scale so the largest lands in [2^29, 2^30)
   logic       c_vld_ff;
   carry_type  c_car_ff, c_car_in;
   logic [W+29:0] wide [3];

   always_comb begin
      c_car_in.side = b_side_ff;
      c_car_in.nz   = (b_pos_ff != '0);
      c_car_in.neg  = b_neg_ff;
      for (int i = 0; i < 3; i++) begin
         wide[i]        = {b_mag_ff[i], 30'b0} >> b_pos_ff;
         c_car_in.n[i]  = wide[i][29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else       c_vld_ff <= b_vld_ff;
   end

   always_ff @(posedge clock) c_car_ff <= c_car_in;

   // stage D: squares
   logic             d_vld_ff;
   carry_type        d_car_ff;
   logic [2:0][59:0] d_sq_ff, d_sq_in;

   always_comb begin
      for (int i = 0; i < 3; i++) d_sq_in[i] = c_car_ff.n[i] * c_car_ff.n[i];
   end

   always_ff @(posedge clock) begin
      if (reset) d_vld_ff <= 1'b0;
      else       d_vld_ff <= c_vld_ff;
   end

   always_ff @(posedge clock) begin
      d_car_ff <= c_car_ff;
      d_sq_ff  <= d_sq_in;
   end

   // square root pipeline; entry 0 holds the sum of squares
   logic        sq_vld_ff [SQRT_STEPS+1];
   logic [63:0] sq_x_ff   [SQRT_STEPS+1];
   logic [63:0] sq_r_ff   [SQRT_STEPS+1];
   carry_type   sq_car_ff [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) sq_vld_ff[0] <= 1'b0;
      else       sq_vld_ff[0] <= d_vld_ff;
   end

   always_ff @(posedge clock) begin
      sq_x_ff[0]   <= {4'b0, d_sq_ff[0]} + {4'b0, d_sq_ff[1]} + {4'b0, d_sq_ff[2]};
      sq_r_ff[0]   <= '0;
      sq_car_ff[0] <= d_car_ff;
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
      logic [63:0] trial, x_in, r_in;

      always_comb begin
         trial = sq_r_ff[j] + BIT;
         if (sq_x_ff[j] >= trial) begin
            x_in = sq_x_ff[j] - trial;
            r_in = (sq_r_ff[j] >> 1) + BIT;
         end else begin
            x_in = sq_x_ff[j];
            r_in = sq_r_ff[j] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) sq_vld_ff[j+1] <= 1'b0;
         else       sq_vld_ff[j+1] <= sq_vld_ff[j];
      end

      always_ff @(posedge clock) begin
         sq_x_ff[j+1]   <= x_in;
         sq_r_ff[j+1]   <= r_in;
         sq_car_ff[j+1] <= sq_car_ff[j];
      end
   end

   // divider pipeline; entry 0 holds numerators m*2^30 + len/2
   logic             dv_vld_ff [DIV_STEPS+1];
   logic [2:0][32:0] dv_rem_ff [DIV_STEPS+1];
   logic [2:0][30:0] dv_q_ff   [DIV_STEPS+1];
   logic [2:0][60:0] dv_num_ff [DIV_STEPS+1];
   logic [31:0]      dv_len_ff [DIV_STEPS+1];
   carry_type        dv_car_ff [DIV_STEPS+1];
   logic [31:0]      len;
   logic [2:0][60:0] num_in;

   always_comb begin
      len = sq_r_ff[SQRT_STEPS][31:0];
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {1'b0, sq_car_ff[SQRT_STEPS].n[i], 30'b0} + {30'b0, len[31:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff[0] <= 1'b0;
      else       dv_vld_ff[0] <= sq_vld_ff[SQRT_STEPS];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) dv_rem_ff[0][i] <= {3'b0, num_in[i][60:31]};
      dv_q_ff[0]   <= '0;
      dv_num_ff[0] <= num_in;
      dv_len_ff[0] <= len;
      dv_car_ff[0] <= sq_car_ff[SQRT_STEPS];
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int B = DIV_STEPS - 1 - j;
      logic [2:0][32:0] pre, rem_in;
      logic [2:0][30:0] q_in;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            pre[i]  = {dv_rem_ff[j][i][31:0], dv_num_ff[j][i][B]};
            q_in[i] = dv_q_ff[j][i];
            if (pre[i] >= {1'b0, dv_len_ff[j]}) begin
               rem_in[i]  = pre[i] - {1'b0, dv_len_ff[j]};
               q_in[i][B] = 1'b1;
            end else begin
               rem_in[i] = pre[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_vld_ff[j+1] <= 1'b0;
         else       dv_vld_ff[j+1] <= dv_vld_ff[j];
      end

      always_ff @(posedge clock) begin
         dv_rem_ff[j+1] <= rem_in;
         dv_q_ff[j+1]   <= q_in;
         dv_num_ff[j+1] <= dv_num_ff[j];
         dv_len_ff[j+1] <= dv_len_ff[j];
         dv_car_ff[j+1] <= dv_car_ff[j];
      end
   end

   // stage G: signs back on
   logic              g_vld_ff;
   logic [2:0][31:0]  g_vec_ff, g_vec_in;
   logic              g_nz_ff;
   logic [SIDE_W-1:0] g_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_vec_in[i] = dv_car_ff[DIV_STEPS].neg[i]
                     ? (~{1'b0, dv_q_ff[DIV_STEPS][i]} + 32'd1)
                     : {1'b0, dv_q_ff[DIV_STEPS][i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) g_vld_ff <= 1'b0;
      else       g_vld_ff <= dv_vld_ff[DIV_STEPS];
   end

   always_ff @(posedge clock) begin
      g_vec_ff  <= g_vec_in;
      g_nz_ff   <= dv_car_ff[DIV_STEPS].nz;
      g_side_ff <= dv_car_ff[DIV_STEPS].side;
   end

   assign out_vld  = g_vld_ff;
   assign out_vec  = g_vec_ff;
   assign out_nz   = g_nz_ff;
   assign out_side = g_side_ff;

endmodule

// ----- hw/rtl/camera_look_at_matrix_core.sv -----
// Look-at view matrix core, top level: config registers and product pipeline.
// Depends on clam_pkg and clam_norm.

// Fully pipelined: busy stays low and a new eye/target word may be started on
// every clock. The result word appears on rsp_word with rsp_strobe high for
// one cycle, and is taken at the edge that ends that cycle; the receiver
// cannot stall it, so sample it that cycle. Each of the two normalizers
// holds a 32-stage square root and a 31-stage divider. Eye equal to target,
// or forward parallel to the up hint, gives an all-zero word. The up hint
// registers sit at byte offsets 0, 4, 8 (x, y, z, Q16.16, reset 0/1.0/0);
// write them only while no word is in flight.
module camera_look_at_matrix_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  clam_pkg::in_type  req_word,
   output logic              rsp_strobe,
   output clam_pkg::out_type rsp_word,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import clam_pkg::*;

   // ---------------- config registers ----------------
   logic [31:0] up_x_ff, up_y_ff, up_z_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_x_ff <= 32'd0;
         up_y_ff <= 32'd65536;
         up_z_ff <= 32'd0;
      end else if (csr_wr) begin
         unique case (csr_idx_type'(paddr[3:2]))
            CSR_UP_X: up_x_ff <= pwdata;
            CSR_UP_Y: up_y_ff <= pwdata;
            CSR_UP_Z: up_z_ff <= pwdata;
            default:  ;   // no register there
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx_type'(paddr[3:2]))
         CSR_UP_X: prdata = up_x_ff;
         CSR_UP_Y: prdata = up_y_ff;
         CSR_UP_Z: prdata = up_z_ff;
         default:  prdata = '0;
      endcase
   end

   // ---------------- T0: latch eye, form center - eye ----------------
   logic                t0_vld_ff;
   logic [2:0][31:0]    t0_eye_ff, t0_eye_in;
   logic [2:0][32:0]    t0_dif_ff, t0_dif_in;
   logic [2:0][31:0]    ctr;

   always_comb begin
      t0_eye_in[0] = req_word.eye_x;
      t0_eye_in[1] = req_word.eye_y;
      t0_eye_in[2] = req_word.eye_z;
      ctr[0]       = req_word.center_x;
      ctr[1]       = req_word.center_y;
      ctr[2]       = req_word.center_z;
      for (int i = 0; i < 3; i++) begin
         t0_dif_in[i] = {ctr[i][31], ctr[i]} - {t0_eye_in[i][31], t0_eye_in[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) t0_vld_ff <= 1'b0;
      else       t0_vld_ff <= start & ~busy;
   end

   always_ff @(posedge clock) begin
      t0_eye_ff <= t0_eye_in;
      t0_dif_ff <= t0_dif_in;
   end

   // ---------------- forward = normalize(center - eye) ----------------
   logic                n1_vld;
   logic [2:0][31:0]    n1_fwd;
   logic                n1_nz;
   logic [SIDE1_W-1:0]  n1_side;

   clam_norm #(
      .W      (D_W),
      .SIDE_W (SIDE1_W)
   ) u_norm_fwd (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (t0_vld_ff),
      .in_vec   (t0_dif_ff),
      .in_side  (t0_eye_ff),
      .out_vld  (n1_vld),
      .out_vec  (n1_fwd),
      .out_nz   (n1_nz),
      .out_side (n1_side)
   );

   // ---------------- T1: forward x up partial products ----------------
   logic                     t1_vld_ff;
   logic signed [63:0]       t1_p_ff [6];
   logic signed [63:0]       t1_p_in [6];
   side2_type                t1_sd_ff, t1_sd_in;

   always_comb begin
      t1_p_in[0] = mul32s(n1_fwd[1], up_z_ff);
      t1_p_in[1] = mul32s(n1_fwd[2], up_y_ff);
      t1_p_in[2] = mul32s(n1_fwd[2], up_x_ff);
      t1_p_in[3] = mul32s(n1_fwd[0], up_z_ff);
      t1_p_in[4] = mul32s(n1_fwd[0], up_y_ff);
      t1_p_in[5] = mul32s(n1_fwd[1], up_x_ff);
      t1_sd_in.nz  = n1_nz;
      t1_sd_in.fwd = n1_fwd;
      t1_sd_in.eye = n1_side;
   end

   always_ff @(posedge clock) begin
      if (reset) t1_vld_ff <= 1'b0;
      else       t1_vld_ff <= n1_vld;
   end

   always_ff @(posedge clock) begin
      t1_p_ff  <= t1_p_in;
      t1_sd_ff <= t1_sd_in;
   end

   // ---------------- T2: side, unnormalized ----------------
   logic             t2_vld_ff;
   logic [2:0][63:0] t2_sr_ff, t2_sr_in;
   side2_type        t2_sd_ff;

   always_comb begin
      t2_sr_in[0] = t1_p_ff[0] - t1_p_ff[1];
      t2_sr_in[1] = t1_p_ff[2] - t1_p_ff[3];
      t2_sr_in[2] = t1_p_ff[4] - t1_p_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) t2_vld_ff <= 1'b0;
      else       t2_vld_ff <= t1_vld_ff;
   end

   always_ff @(posedge clock) begin
      t2_sr_ff <= t2_sr_in;
      t2_sd_ff <= t1_sd_ff;
   end

   // ---------------- side = normalize(forward x up) ----------------
   logic                n2_vld;
   logic [2:0][31:0]    n2_side_v;
   logic                n2_nz;
   logic [SIDE2_W-1:0]  n2_side;
   side2_type           n2_sd;

   clam_norm #(
      .W      (SR_W),
      .SIDE_W (SIDE2_W)
   ) u_norm_side (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (t2_vld_ff),
      .in_vec   (t2_sr_ff),
      .in_side  (t2_sd_ff),
      .out_vld  (n2_vld),
      .out_vec  (n2_side_v),
      .out_nz   (n2_nz),
      .out_side (n2_side)
   );

   assign n2_sd = side2_type'(n2_side);

   // ---------------- T3: s x f, s.eye and f.eye products ----------------
   logic               t3_vld_ff, t3_ok_ff;
   logic [2:0][31:0]   t3_s_ff, t3_f_ff, t3_e_ff;
   logic signed [63:0] t3_up_ff [6];
   logic signed [63:0] t3_up_in [6];
   logic signed [63:0] t3_se_ff [3];
   logic signed [63:0] t3_se_in [3];
   logic signed [63:0] t3_fe_ff [3];
   logic signed [63:0] t3_fe_in [3];

   always_comb begin
      t3_up_in[0] = mul32s(n2_side_v[1], n2_sd.fwd[2]);
      t3_up_in[1] = mul32s(n2_side_v[2], n2_sd.fwd[1]);
      t3_up_in[2] = mul32s(n2_side_v[2], n2_sd.fwd[0]);
      t3_up_in[3] = mul32s(n2_side_v[0], n2_sd.fwd[2]);
      t3_up_in[4] = mul32s(n2_side_v[0], n2_sd.fwd[1]);
      t3_up_in[5] = mul32s(n2_side_v[1], n2_sd.fwd[0]);
      for (int i = 0; i < 3; i++) begin
         t3_se_in[i] = mul32s(n2_side_v[i], n2_sd.eye[i]);
         t3_fe_in[i] = mul32s(n2_sd.fwd[i], n2_sd.eye[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) t3_vld_ff <= 1'b0;
      else       t3_vld_ff <= n2_vld;
   end

   always_ff @(posedge clock) begin
      t3_ok_ff <= n2_nz & n2_sd.nz;
      t3_s_ff  <= n2_side_v;
      t3_f_ff  <= n2_sd.fwd;
      t3_e_ff  <= n2_sd.eye;
      t3_up_ff <= t3_up_in;
      t3_se_ff <= t3_se_in;
      t3_fe_ff <= t3_fe_in;
   end

   // ---------------- T4: cross differences and dot sums ----------------
   logic               t4_vld_ff, t4_ok_ff;
   logic [2:0][31:0]   t4_s_ff, t4_f_ff, t4_e_ff;
   logic signed [63:0] t4_ud_ff [3];
   logic signed [63:0] t4_se_ff, t4_fe_ff;

   always_ff @(posedge clock) begin
      if (reset) t4_vld_ff <= 1'b0;
      else       t4_vld_ff <= t3_vld_ff;
   end

   always_ff @(posedge clock) begin
      t4_ok_ff    <= t3_ok_ff;
      t4_s_ff     <= t3_s_ff;
      t4_f_ff     <= t3_f_ff;
      t4_e_ff     <= t3_e_ff;
      t4_ud_ff[0] <= t3_up_ff[0] - t3_up_ff[1];
      t4_ud_ff[1] <= t3_up_ff[2] - t3_up_ff[3];
      t4_ud_ff[2] <= t3_up_ff[4] - t3_up_ff[5];
      t4_se_ff    <= t3_se_ff[0] + t3_se_ff[1] + t3_se_ff[2];
      t4_fe_ff    <= t3_fe_ff[0] + t3_fe_ff[1] + t3_fe_ff[2];
   end

   // ---------------- T5: round camera up, round s.eye and f.eye ----------------
   logic               t5_vld_ff, t5_ok_ff;
   logic [2:0][31:0]   t5_s_ff, t5_f_ff, t5_e_ff, t5_u_ff;
   logic signed [63:0] t5_se_ff, t5_fe_ff;

   always_ff @(posedge clock) begin
      if (reset) t5_vld_ff <= 1'b0;
      else       t5_vld_ff <= t4_vld_ff;
   end

   always_ff @(posedge clock) begin
      t5_ok_ff <= t4_ok_ff;
      t5_s_ff  <= t4_s_ff;
      t5_f_ff  <= t4_f_ff;
      t5_e_ff  <= t4_e_ff;
      for (int i = 0; i < 3; i++) t5_u_ff[i] <= sat30(round30(t4_ud_ff[i]));
      t5_se_ff <= round30(t4_se_ff);
      t5_fe_ff <= round30(t4_fe_ff);
   end

   // ---------------- T6: u.eye products ----------------
   logic               t6_vld_ff, t6_ok_ff;
   logic [2:0][31:0]   t6_s_ff, t6_f_ff, t6_u_ff;
   logic signed [63:0] t6_se_ff, t6_fe_ff;
   logic signed [63:0] t6_ue_ff [3];

   always_ff @(posedge clock) begin
      if (reset) t6_vld_ff <= 1'b0;
      else       t6_vld_ff <= t5_vld_ff;
   end

   always_ff @(posedge clock) begin
      t6_ok_ff <= t5_ok_ff;
      t6_s_ff  <= t5_s_ff;
      t6_f_ff  <= t5_f_ff;
      t6_u_ff  <= t5_u_ff;
      t6_se_ff <= t5_se_ff;
      t6_fe_ff <= t5_fe_ff;
      for (int i = 0; i < 3; i++) t6_ue_ff[i] <= mul32s(t5_u_ff[i], t5_e_ff[i]);
   end

   // ---------------- T7: u.eye sum ----------------
   logic               t7_vld_ff, t7_ok_ff;
   logic [2:0][31:0]   t7_s_ff, t7_f_ff, t7_u_ff;
   logic signed [63:0] t7_se_ff, t7_fe_ff, t7_ue_ff;

   always_ff @(posedge clock) begin
      if (reset) t7_vld_ff <= 1'b0;
      else       t7_vld_ff <= t6_vld_ff;
   end

   always_ff @(posedge clock) begin
      t7_ok_ff <= t6_ok_ff;
      t7_s_ff  <= t6_s_ff;
      t7_f_ff  <= t6_f_ff;
      t7_u_ff  <= t6_u_ff;
      t7_se_ff <= t6_se_ff;
      t7_fe_ff <= t6_fe_ff;
      t7_ue_ff <= t6_ue_ff[0] + t6_ue_ff[1] + t6_ue_ff[2];
   end

   // ---------------- T8: output word register ----------------
   logic               rsp_vld_ff;
   out_type            rsp_word_ff, rsp_word_in;
   logic signed [63:0] ts, tu, tf;

   always_comb begin
      ts = -t7_se_ff;
      tu = -round30(t7_ue_ff);
      tf = t7_fe_ff;
      rsp_word_in.side_x     = t7_s_ff[0];
      rsp_word_in.side_y     = t7_s_ff[1];
      rsp_word_in.side_z     = t7_s_ff[2];
      rsp_word_in.cam_up_x   = t7_u_ff[0];
      rsp_word_in.cam_up_y   = t7_u_ff[1];
      rsp_word_in.cam_up_z   = t7_u_ff[2];
      rsp_word_in.back_x     = ~t7_f_ff[0] + 32'd1;
      rsp_word_in.back_y     = ~t7_f_ff[1] + 32'd1;
      rsp_word_in.back_z     = ~t7_f_ff[2] + 32'd1;
      rsp_word_in.trans_side = ts[39:0];
      rsp_word_in.trans_up   = tu[39:0];
      rsp_word_in.trans_fwd  = tf[39:0];
      // degenerate pose: zero difference or forward parallel to up
      if (!t7_ok_ff) rsp_word_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else       rsp_vld_ff <= t7_vld_ff;
   end

   always_ff @(posedge clock) rsp_word_ff <= rsp_word_in;

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
